// File: hw/rtl/swm_pkg.sv
// Shared constants and types for the sliding window maximum block.
package swm_pkg;

  localparam int CFG_W           = 7;
  localparam int WINDOW_SIZE_RST = 3;
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;

  typedef struct packed {
    logic step;
    logic shift;
    logic clear;
  } swm_ctl_t;

endpackage

// File: hw/rtl/swm_cell.sv
// One candidate cell of the monotonic queue chain: value, position and valid bit.
module swm_cell #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
  parameter int POS_W       = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swm_pkg::swm_ctl_t             ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic        [POS_W-1:0]       cur_pos,
  input  logic                          up_vld,
  input  logic signed [SAMPLE_BITS-1:0] up_val,
  input  logic        [POS_W-1:0]       up_pos,
  input  logic                          up_keep,
  input  logic                          front_keep,
  output logic                          vld,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic        [POS_W-1:0]       pos,
  output logic                          keep
);
  import swm_pkg::*;

  logic                          vld_r, vld_nxt;
  logic signed [SAMPLE_BITS-1:0] val_r, val_nxt;
  logic        [POS_W-1:0]       pos_r, pos_nxt;
  logic                          src_vld, src_keep;
  logic signed [SAMPLE_BITS-1:0] src_val;
  logic        [POS_W-1:0]       src_pos;

  assign keep = vld_r && (val_r >= sample);

  always_comb begin
    src_vld  = ctl.shift ? up_vld  : vld_r;
    src_val  = ctl.shift ? up_val  : val_r;
    src_pos  = ctl.shift ? up_pos  : pos_r;
    src_keep = ctl.shift ? up_keep : keep;
    vld_nxt  = vld_r;
    val_nxt  = val_r;
    pos_nxt  = pos_r;
    if (ctl.step) begin
      if (src_keep) begin
        vld_nxt = 1'b1;
        val_nxt = src_val;
        pos_nxt = src_pos;
      end else if (front_keep) begin
        vld_nxt = 1'b1;
        val_nxt = sample;
        pos_nxt = cur_pos;
      end else begin
        vld_nxt = 1'b0;
      end
    end else if (ctl.shift) begin
      vld_nxt = src_vld;
      val_nxt = src_val;
      pos_nxt = src_pos;
    end
    if (ctl.clear) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    val_r <= val_nxt;
    pos_r <= pos_nxt;
  end

  assign vld = vld_r;
  assign val = val_r;
  assign pos = pos_r;

endmodule

// File: hw/rtl/sliding_window_maximum.sv
// Top level of the sliding window maximum block: cell chain, counters and result register.
// Sliding window maximum: one signed sample per request on the in_ channel; once
// window_size samples of the current sequence have arrived, every sample yields one
// request on the out_ channel with the maximum of the last window_size samples, in the
// cycle after it was taken. The candidate queue is a chain of WINDOW_MAX cells that
// all compare against the new sample at once, so a sample is taken every cycle unless
// in_stall is high. After window_size is lowered, the chain retires one out-of-window
// front candidate per cycle, and the next sample waits while more than one such
// candidate sits at the front. in_stall is also high while a result sits in the
// output register and out_stall holds it. A sample with in_last_sample set ends the
// sequence and clears the chain. window_size of 0 acts as 1, above WINDOW_MAX as
// WINDOW_MAX; write it only while the block is idle. cfg_ready is always high.
module sliding_window_maximum #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0]     cfg_window_size,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_window_max
);
  import swm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int EXT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]              window_size_r;
  logic [EXT_W-1:0]              ws_ext;
  logic [CNT_W-1:0]              win;
  logic [CNT_W-1:0]              pos_r, pos_nxt;
  logic [CNT_W-1:0]              seen_r, seen_nxt, seen_clamp;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_max_r, out_max_nxt;
  logic                          c_vld  [0:WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] c_val  [0:WINDOW_MAX];
  logic        [CNT_W-1:0]       c_pos  [0:WINDOW_MAX];
  logic                          c_keep [0:WINDOW_MAX];
  logic        [WINDOW_MAX:0]    vld_vec;
  logic        [CNT_W-1:0]       age0, age1;
  logic                          stale0, stale1, purge, step, produce;
  logic                          front_src_keep;
  logic signed [SAMPLE_BITS-1:0] front_val;
  swm_ctl_t                      ctl;

  assign cfg_ready = 1'b1;

  always_comb begin
    ws_ext = EXT_W'(window_size_r);
    if (ws_ext == '0) begin
      win = CNT_W'(1);
    end else if (ws_ext > EXT_W'(WINDOW_MAX)) begin
      win = CNT_W'(WINDOW_MAX);
    end else begin
      win = CNT_W'(ws_ext);
    end
  end

  assign c_vld[WINDOW_MAX]  = 1'b0;
  assign c_val[WINDOW_MAX]  = '0;
  assign c_pos[WINDOW_MAX]  = '0;
  assign c_keep[WINDOW_MAX] = 1'b0;

  assign age0   = pos_r - c_pos[0];
  assign age1   = pos_r - c_pos[1];
  assign stale0 = c_vld[0] && (age0 >= win);
  assign stale1 = c_vld[1] && (age1 >= win);
  assign purge  = stale0 && stale1;

  assign in_stall = purge || (out_valid_r && out_stall);
  assign step     = in_valid && !in_stall;

  assign ctl.step  = step;
  assign ctl.shift = purge || (step && stale0);
  assign ctl.clear = step && in_last_sample;

  genvar j;
  generate
    for (j = 0; j < WINDOW_MAX; j++) begin : g_cell
      logic front_keep;
      if (j == 0) begin : g_front
        assign front_keep = 1'b1;
      end else begin : g_rest
        assign front_keep = ctl.shift ? c_keep[j] : c_keep[j-1];
      end
      swm_cell #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .POS_W      (CNT_W)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sample    (in_sample),
        .cur_pos   (pos_r),
        .up_vld    (c_vld[j+1]),
        .up_val    (c_val[j+1]),
        .up_pos    (c_pos[j+1]),
        .up_keep   (c_keep[j+1]),
        .front_keep(front_keep),
        .vld       (c_vld[j]),
        .val       (c_val[j]),
        .pos       (c_pos[j]),
        .keep      (c_keep[j])
      );
    end
    for (j = 0; j <= WINDOW_MAX; j++) begin : g_vec
      assign vld_vec[j] = c_vld[j];
    end
  endgenerate

  always_comb begin
    front_src_keep = ctl.shift ? c_keep[1] : c_keep[0];
    front_val      = front_src_keep ? (ctl.shift ? c_val[1] : c_val[0]) : in_sample;
    seen_clamp     = (seen_r > win) ? win : seen_r;
    seen_nxt       = seen_r;
    pos_nxt        = pos_r;
    produce        = 1'b0;
    if (step) begin
      seen_nxt = (seen_clamp < win) ? seen_clamp + CNT_W'(1) : seen_clamp;
      pos_nxt  = pos_r + CNT_W'(1);
      produce  = (seen_nxt >= win);
      if (in_last_sample) begin
        seen_nxt = '0;
        pos_nxt  = '0;
      end
    end
    out_valid_nxt = out_valid_r && out_stall;
    out_max_nxt   = out_max_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
      out_max_nxt   = front_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= CFG_W'(WINDOW_SIZE_RST);
      pos_r         <= '0;
      seen_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_size_r <= cfg_window_size;
      end
      pos_r       <= pos_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_max_r <= out_max_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_max_r;

`ifndef SYNTH
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(vld_vec + 1'b1))
    else $error("candidate valid bits not a prefix");

  a_front_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !in_last_sample) |=> c_vld[0])
    else $error("front cell empty after a sample");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_last_sample) |=> (!c_vld[0] && seen_r == '0 && pos_r == '0))
    else $error("sequence state not cleared after last sample");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (seen_r <= $past(win)))
    else $error("sample count above window length");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step))
    else $error("result without an accepted sample");
`endif

endmodule
